[rtl/cwpf_pkg.sv]
// Shared types, constants and the CRC byte update for the write packet framer.
// No dependencies.
`timescale 1ns / 1ps

package cwpf_pkg;

  localparam logic [15:0] CRC_POLY = 16'h8005;

  localparam logic [7:0] INSTR_RESET = 8'd3;

  localparam logic [7:0] HDR_SYNC   = 8'hFF;
  localparam logic [7:0] HDR_MARK   = 8'hFD;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] LEN_NARROW = 8'd7;
  localparam logic [7:0] LEN_WIDE   = 8'd9;

  // Byte positions inside a packet
  localparam logic [3:0] POS_SYNC0   = 4'd0;
  localparam logic [3:0] POS_SYNC1   = 4'd1;
  localparam logic [3:0] POS_MARK    = 4'd2;
  localparam logic [3:0] POS_RSVD    = 4'd3;
  localparam logic [3:0] POS_ID      = 4'd4;
  localparam logic [3:0] POS_LEN_LO  = 4'd5;
  localparam logic [3:0] POS_LEN_HI  = 4'd6;
  localparam logic [3:0] POS_INSTR   = 4'd7;
  localparam logic [3:0] POS_ADDR_LO = 4'd8;
  localparam logic [3:0] POS_ADDR_HI = 4'd9;
  localparam logic [3:0] POS_VAL0    = 4'd10;
  localparam logic [3:0] POS_VAL1    = 4'd11;
  localparam logic [3:0] POS_VAL2    = 4'd12;
  localparam logic [3:0] POS_VAL3    = 4'd13;
  localparam logic [3:0] POS_W_CRCLO = 4'd14;
  localparam logic [3:0] POS_W_CRCHI = 4'd15;

  localparam logic [3:0] LAST_NARROW = 4'd13;
  localparam logic [3:0] LAST_WIDE   = 4'd15;

  typedef struct packed {
    logic [7:0]  servo_id;
    logic [15:0] reg_addr;
    logic [31:0] write_value;
    logic        wide;
    logic [7:0]  instr;
    logic [7:0]  len_byte;
    logic [3:0]  last_pos;
  } req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/cwpf_front.sv]
// Front end: takes write requests, classifies width, builds the queue record.
// Depends on cwpf_pkg.
`timescale 1ns / 1ps

module cwpf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_servo_id,
  input  logic [15:0]         in_reg_addr,
  input  logic [31:0]         in_write_value,
  input  logic                in_wide_write,
  input  logic [7:0]          instr,
  input  logic                q_full,
  output logic                q_push,
  output cwpf_pkg::req_t      q_wdata
);

  logic           valid_r, valid_nxt;
  cwpf_pkg::req_t req_r, req_nxt;
  logic           accept;

  assign q_push   = valid_r && !q_full;
  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_wdata  = req_r;

  always_comb begin
    valid_nxt = valid_r;
    req_nxt   = req_r;
    if (q_push) begin
      valid_nxt = 1'b0;
    end
    if (accept) begin
      valid_nxt           = 1'b1;
      req_nxt.servo_id    = in_servo_id;
      req_nxt.reg_addr    = in_reg_addr;
      req_nxt.write_value = in_write_value;
      req_nxt.wide        = in_wide_write;
      req_nxt.instr       = instr;
      req_nxt.len_byte    = in_wide_write ? cwpf_pkg::LEN_WIDE : cwpf_pkg::LEN_NARROW;
      req_nxt.last_pos    = in_wide_write ? cwpf_pkg::LAST_WIDE : cwpf_pkg::LAST_NARROW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    req_r <= req_nxt;
  end

endmodule

[rtl/cwpf_queue.sv]
// Two-entry request queue between front end and byte serializer.
// Depends on cwpf_pkg.
`timescale 1ns / 1ps

module cwpf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cwpf_pkg::req_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output cwpf_pkg::req_t rdata
);

  cwpf_pkg::req_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/cwpf_back.sv]
// Back end: walks the head request byte by byte, runs the CRC, drives the output register.
// Depends on cwpf_pkg.
`timescale 1ns / 1ps

module cwpf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  cwpf_pkg::req_t q_rdata,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_tx_byte,
  output logic           out_last_byte
);

  logic [3:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        ol_r, ol_nxt;

  logic        load, emit, is_last;
  logic [15:0] crc_base;
  logic [7:0]  cur_byte;
  logic        is_crc;

  assign load     = !ov_r || !out_stall;
  assign emit     = q_valid && load;
  assign is_last  = (pos_r == q_rdata.last_pos);
  assign q_pop    = emit && is_last;
  // fresh CRC at the first byte of each packet
  assign crc_base = (pos_r == cwpf_pkg::POS_SYNC0) ? 16'h0000 : crc_r;

  always_comb begin
    is_crc = 1'b0;
    unique case (pos_r)
      cwpf_pkg::POS_SYNC0:   cur_byte = cwpf_pkg::HDR_SYNC;
      cwpf_pkg::POS_SYNC1:   cur_byte = cwpf_pkg::HDR_SYNC;
      cwpf_pkg::POS_MARK:    cur_byte = cwpf_pkg::HDR_MARK;
      cwpf_pkg::POS_RSVD:    cur_byte = cwpf_pkg::BYTE_ZERO;
      cwpf_pkg::POS_ID:      cur_byte = q_rdata.servo_id;
      cwpf_pkg::POS_LEN_LO:  cur_byte = q_rdata.len_byte;
      cwpf_pkg::POS_LEN_HI:  cur_byte = cwpf_pkg::BYTE_ZERO;
      cwpf_pkg::POS_INSTR:   cur_byte = q_rdata.instr;
      cwpf_pkg::POS_ADDR_LO: cur_byte = q_rdata.reg_addr[7:0];
      cwpf_pkg::POS_ADDR_HI: cur_byte = q_rdata.reg_addr[15:8];
      cwpf_pkg::POS_VAL0:    cur_byte = q_rdata.write_value[7:0];
      cwpf_pkg::POS_VAL1:    cur_byte = q_rdata.write_value[15:8];
      cwpf_pkg::POS_VAL2: begin
        // narrow packets put the CRC trailer here
        is_crc   = !q_rdata.wide;
        cur_byte = q_rdata.wide ? q_rdata.write_value[23:16] : crc_r[7:0];
      end
      cwpf_pkg::POS_VAL3: begin
        is_crc   = !q_rdata.wide;
        cur_byte = q_rdata.wide ? q_rdata.write_value[31:24] : crc_r[15:8];
      end
      cwpf_pkg::POS_W_CRCLO: begin
        is_crc   = 1'b1;
        cur_byte = crc_r[7:0];
      end
      cwpf_pkg::POS_W_CRCHI: begin
        is_crc   = 1'b1;
        cur_byte = crc_r[15:8];
      end
      default: cur_byte = cwpf_pkg::BYTE_ZERO;
    endcase
  end

  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    ov_nxt  = ov_r;
    ob_nxt  = ob_r;
    ol_nxt  = ol_r;
    if (load) begin
      ov_nxt = emit;
    end
    if (emit) begin
      ob_nxt  = cur_byte;
      ol_nxt  = is_last;
      pos_nxt = is_last ? cwpf_pkg::POS_SYNC0 : pos_r + 4'd1;
      if (!is_crc) begin
        crc_nxt = cwpf_pkg::crc_byte(crc_base, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= cwpf_pkg::POS_SYNC0;
      ov_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ov_r  <= ov_nxt;
    end
    crc_r <= crc_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_valid     = ov_r;
  assign out_tx_byte   = ob_r;
  assign out_last_byte = ol_r;

endmodule

[rtl/crc16_write_packet_framer.sv]
// Top level of the write packet framer: config register, front end, queue, serializer.
// Depends on cwpf_pkg, cwpf_front, cwpf_queue, cwpf_back.
`timescale 1ns / 1ps

// Usage
//  - Input channel (in_*): one write request per word: servo id, register
//    address, 32-bit value and a wide flag. Accepted when in_valid is high
//    and in_stall is low.
//  - Output channel (out_*): one packet byte per word, out_last_byte marks
//    the CRC high byte closing a packet. The receiver holds out_stall high
//    to pause; the byte on the port holds still while stalled.
//  - cfg_wr_en/cfg_wr_data write the instruction byte (reset value 3). It is
//    sampled when a request enters, so write it only while the block is idle.
//  - Path: an accepted request is held in the input register, written into the
//    queue, and its first byte is then loaded into the output register.
//  - Throughput: one byte per cycle while out_stall is low; a narrow request
//    is 14 bytes and a wide one 16. The rate is set by the single byte serializer
//    and its CRC step; packets follow with no gap while the next one is queued.
//  - The two-entry queue (head = request being serialized) plus the input register
//    hold up to three requests, so two more wait while busy or the receiver stalls.
//  - Reset (rst_n low, synchronous) empties the queue and the output stage
//    and restores the instruction byte.

module crc16_write_packet_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_servo_id,
  input  logic [15:0] in_reg_addr,
  input  logic [31:0] in_write_value,
  input  logic        in_wide_write,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_last_byte,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic [7:0] instr_r, instr_nxt;

  logic           q_full, q_push, q_pop, q_valid;
  cwpf_pkg::req_t q_wdata, q_rdata;

  assign instr_nxt = cfg_wr_en ? cfg_wr_data : instr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      instr_r <= cwpf_pkg::INSTR_RESET;
    end else begin
      instr_r <= instr_nxt;
    end
  end

  cwpf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_servo_id    (in_servo_id),
    .in_reg_addr    (in_reg_addr),
    .in_write_value (in_write_value),
    .in_wide_write  (in_wide_write),
    .instr          (instr_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  cwpf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  cwpf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

[tb/tb.sv]
// Self-checking bench for crc16_write_packet_framer: directed and random write
// requests, every packet byte checked against a local framing and CRC-16 model.
// Depends on cwpf_pkg (header, length, reset instruction and polynomial constants) and the framer RTL.
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 12;    // settle time after the last expected byte is seen
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_REQS     = 80;    // 6 x 80 = 480 random requests

  typedef struct {
    logic [7:0]  servo_id;
    logic [15:0] reg_addr;
    logic [31:0] write_value;
    logic        wide_write;
  } wr_req_t;

  typedef struct {
    logic [7:0] tx_byte;
    logic       last_byte;
  } pkt_byte_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_BURSTY, STALL_HEAVY} stall_mode_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic [7:0]  in_servo_id    = '0;
  logic [15:0] in_reg_addr    = '0;
  logic [31:0] in_write_value = '0;
  logic        in_wide_write  = 1'b0;
  logic        out_stall      = 1'b0;
  logic        cfg_wr_en      = 1'b0;
  logic [7:0]  cfg_wr_data    = '0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_tx_byte;
  logic        out_last_byte;

  crc16_write_packet_framer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_servo_id    (in_servo_id),
    .in_reg_addr    (in_reg_addr),
    .in_write_value (in_write_value),
    .in_wide_write  (in_wide_write),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tx_byte    (out_tx_byte),
    .out_last_byte  (out_last_byte),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Model state: instruction byte as last written, requests waiting to be
  // driven, packet bytes expected on the output in order.
  logic [7:0] instr_shadow = cwpf_pkg::INSTR_RESET;
  wr_req_t    req_q[$];
  pkt_byte_t  pkt_q[$];
  int         mismatches = 0;

  // Bit-serial CRC-16, poly 0x8005, MSB first, no reflection.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ data[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ cwpf_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  // Build the whole packet for one accepted request and queue its bytes.
  function automatic void expect_packet(input wr_req_t r);
    logic [7:0]  pkt [16];
    logic [15:0] crc;
    int          n;
    pkt[0]  = cwpf_pkg::HDR_SYNC;
    pkt[1]  = cwpf_pkg::HDR_SYNC;
    pkt[2]  = cwpf_pkg::HDR_MARK;
    pkt[3]  = cwpf_pkg::BYTE_ZERO;
    pkt[4]  = r.servo_id;
    pkt[5]  = r.wide_write ? cwpf_pkg::LEN_WIDE : cwpf_pkg::LEN_NARROW;
    pkt[6]  = cwpf_pkg::BYTE_ZERO;
    pkt[7]  = instr_shadow;
    pkt[8]  = r.reg_addr[7:0];
    pkt[9]  = r.reg_addr[15:8];
    pkt[10] = r.write_value[7:0];
    pkt[11] = r.write_value[15:8];
    n = 12;
    // narrow write drops the upper half of the value
    if (r.wide_write) begin
      pkt[12] = r.write_value[23:16];
      pkt[13] = r.write_value[31:24];
      n = 14;
    end
    crc = '0;
    for (int i = 0; i < n; i++) begin
      crc = crc16_update(crc, pkt[i]);
    end
    pkt[n]   = crc[7:0];
    pkt[n+1] = crc[15:8];
    n = n + 2;
    for (int i = 0; i < n; i++) begin
      pkt_q.push_back('{tx_byte: pkt[i], last_byte: (i == n - 1)});
    end
  endfunction

  function automatic void flag_bad_byte(input string why, input logic [7:0] exp_b,
                                        input logic exp_l);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $time, why, exp_b, exp_l, out_tx_byte, out_last_byte);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops requests from req_q in bursts of random length with random
  // gaps. Prediction happens at the edge where a word is accepted, so it uses
  // the instruction byte in force at that moment.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    wr_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expect_packet('{servo_id: in_servo_id, reg_addr: in_reg_addr,
                        write_value: in_write_value, wide_write: in_wide_write});
      end
      // payload only moves when the current word is gone or none is offered
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          nxt = req_q.pop_front();
          in_servo_id    <= nxt.servo_id;
          in_reg_addr    <= nxt.reg_addr;
          in_write_value <= nxt.write_value;
          in_wide_write  <= nxt.wide_write;
          in_valid       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            // about a quarter of the bursts run straight into the next one
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted byte against the oldest expected one and
  // drives out_stall from a mode that is redrawn whenever its countdown runs out.
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 100;
  int          run_left   = 0;

  always @(posedge clk) begin
    pkt_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pkt_q.size() == 0) begin
        flag_bad_byte("unexpected word", 8'h00, 1'b0);
      end else begin
        want = pkt_q.pop_front();
        if (out_tx_byte !== want.tx_byte || out_last_byte !== want.last_byte) begin
          flag_bad_byte("wrong word", want.tx_byte, want.last_byte);
        end
      end
    end

    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(64, 256);
    end else begin
      mode_left <= mode_left - 1;
    end

    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_LIGHT: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      STALL_BURSTY: begin
        // alternating runs of stall and release, each of random length
        if (run_left == 0) begin
          out_stall <= !out_stall;
          run_left  <= $urandom_range(1, 6);
        end else begin
          run_left <= run_left - 1;
        end
      end
      default: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // Watchdog: a hung handshake on either side ends the run.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------------
  function automatic void add_req(input logic [7:0] id, input logic [15:0] addr,
                                  input logic [31:0] value, input logic wide);
    req_q.push_back('{servo_id: id, reg_addr: addr, write_value: value, wide_write: wide});
  endfunction

  // Random content, with all-zero and all-one fields mixed in.
  function automatic wr_req_t random_request();
    wr_req_t r;
    r.servo_id    = 8'($urandom_range(0, 255));
    r.reg_addr    = 16'($urandom_range(0, 65535));
    r.write_value = $urandom;
    r.wide_write  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: r.write_value = '0;
      1: r.write_value = '1;
      2: begin
        r.servo_id = '0;
        r.reg_addr = '0;
      end
      3: begin
        r.servo_id = '1;
        r.reg_addr = '1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Idle = every request taken and every expected byte seen, then let the
  // pipeline settle before touching the instruction register.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (req_q.size() != 0 || in_valid || pkt_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_instr(input logic [7:0] value);
    @(posedge clk);
    cfg_wr_en    <= 1'b1;
    cfg_wr_data  <= value;
    instr_shadow  = value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
  endtask

  initial begin
    logic [7:0] instr_pick;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at the reset instruction byte: field extremes, both
    // widths, alternating and walking bits, narrow writes with junk upper half.
    add_req(8'h00, 16'h0000, 32'h0000_0000, 1'b0);
    add_req(8'h00, 16'h0000, 32'h0000_0000, 1'b1);
    add_req(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_req(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    add_req(8'h01, 16'h1234, 32'hDEAD_0000, 1'b0);
    add_req(8'h02, 16'h0040, 32'hFFFF_5A5A, 1'b0);
    add_req(8'hAA, 16'hAAAA, 32'hAAAA_AAAA, 1'b1);
    add_req(8'h55, 16'h5555, 32'h5555_5555, 1'b1);
    add_req(8'hAA, 16'h5555, 32'hAAAA_5555, 1'b0);
    add_req(8'h80, 16'h8000, 32'h8000_0000, 1'b1);
    add_req(8'h01, 16'h0001, 32'h0000_0001, 1'b1);
    add_req(8'h7F, 16'h00FF, 32'h00FF_FF00, 1'b1);
    add_req(8'hFE, 16'hFF00, 32'h1234_5678, 1'b1);
    add_req(8'hFE, 16'hFF00, 32'h1234_5678, 1'b1);
    add_req(8'h10, 16'h0074, 32'h0000_0200, 1'b0);

    // Random phases, each at its own instruction byte (extremes first).
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      case (p)
        0:       instr_pick = 8'hFF;
        1:       instr_pick = 8'h00;
        3:       instr_pick = 8'h80;
        5:       instr_pick = 8'h03;
        default: instr_pick = 8'($urandom_range(0, 255));
      endcase
      write_instr(instr_pick);
      @(negedge clk);
      for (int k = 0; k < PHASE_REQS; k++) begin
        req_q.push_back(random_request());
      end
    end

    wait_idle();
    if (mismatches == 0 && pkt_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
